>>> rtl/core/sge_pkg.sv
// ----------------------------------------------------------------------------
// sge_pkg: shared types and constants for the sigmoid pipeline
// Fixed formats, the exp(-2^j) factor ROM, and the exponent stage record.
// ----------------------------------------------------------------------------
package sge_pkg;

  localparam int X_WIDTH      = 16;  // input element width, Q4.11
  localparam int IN_FRAC_BITS = 11;  // fraction bits of the input element
  localparam int ROM_LOW_EXP  = 14;  // ROM entry 0 holds exp(-2^-14)
  localparam int EXP_W        = 32;  // Q0.32 exponential accumulator

  // Record that travels down the exponent chain.
  typedef struct packed {
    logic               last;
    logic               neg;
    logic [X_WIDTH-1:0] mag;
    logic               one;   // accumulator still equals 1.0
    logic [EXP_W-1:0]   acc;   // Q0.32, valid when one is low
  } exp_data_t;

  // round(exp(-2^j) * 2^32) for j = idx - ROM_LOW_EXP; zero past the table.
  function automatic logic [EXP_W-1:0] exp_factor(input int idx);
    logic [EXP_W-1:0] f;
    unique case (idx)
      0:       f = 32'd4294705160;
      1:       f = 32'd4294443040;
      2:       f = 32'd4293918848;
      3:       f = 32'd4292870656;
      4:       f = 32'd4290775039;
      5:       f = 32'd4286586875;
      6:       f = 32'd4278222805;
      7:       f = 32'd4261543595;
      8:       f = 32'd4228380000;
      9:       f = 32'd4162825044;
      10:      f = 32'd4034748382;
      11:      f = 32'd3790295335;
      12:      f = 32'd3344923893;
      13:      f = 32'd2605029347;
      14:      f = 32'd1580030169;
      15:      f = 32'd581260615;
      16:      f = 32'd78665070;
      17:      f = 32'd1440801;
      18:      f = 32'd483;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

>>> rtl/core/sge_if.sv
// ----------------------------------------------------------------------------
// sge_if: valid/ready stream interfaces of the sigmoid block
// Input carries one Q4.11 element, output one Q0.OUT_BITS result.
// ----------------------------------------------------------------------------
interface sge_in_if;
  logic                         valid;
  logic                         ready;
  logic [sge_pkg::X_WIDTH-1:0]  x_value;
  logic                         last_in;

  modport source (output valid, output x_value, output last_in, input ready);
  modport sink   (input valid, input x_value, input last_in, output ready);
endinterface

interface sge_out_if #(
  parameter int OUT_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] y_value;
  logic                last_out;

  modport source (output valid, output y_value, output last_out, input ready);
  modport sink   (input valid, input y_value, input last_out, output ready);
endinterface

>>> rtl/core/sigmoid_elementwise.sv
// ----------------------------------------------------------------------------
// sigmoid_elementwise: streaming logistic sigmoid, one element per clock unless stalled
// Input in_chan: signed Q4.11 element plus a last flag. Output out_chan:
// unsigned Q0.OUT_BITS sigmoid, saturated at 2^OUT_BITS - 1, with the flag.
// Both channels are valid/ready; a request moves when both are high.
// The block computes e = exp(-|x|) as a product of exp(-2^j) factors, one
// 32x32 multiplier stage per magnitude bit (16 stages), then divides by
// 1+e in a restoring divider with one 34-bit subtract stage per quotient
// bit (OUT_BITS+1 stages). Around that sit an entry register (magnitude),
// a dividend register and the output register.
// Throughput: one element per cycle while the receiver takes results.
// Elements are independent; there is no state beyond the pipeline.
// Reset clears all valid bits; no result is pending afterwards.
// When the receiver stalls, the whole pipeline holds and in_chan.ready
// drops only while the output register is full and not taken; a stall
// loses and repeats nothing.
// ----------------------------------------------------------------------------
module sigmoid_elementwise #(
  parameter int OUT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sge_in_if.sink     in_chan,
  sge_out_if.source  out_chan
);

  localparam int XW    = sge_pkg::X_WIDTH;
  localparam int NW    = OUT_BITS + 34;       // dividend width
  localparam int DIV_N = OUT_BITS + 1;        // quotient bits

  logic en;

  // entry stage
  sge_pkg::exp_data_t entry_nxt;
  logic               neg;

  // exponent chain, index 0 is the entry register
  logic               exp_valid [XW+1];
  sge_pkg::exp_data_t exp_data  [XW+1];

  // dividend stage
  logic [32:0]   e_full;
  logic [33:0]   den_nxt;
  logic [32:0]   num;
  logic [NW-1:0] dividend;

  // divider chain, index 0 is the dividend register
  logic                div_valid [DIV_N+1];
  logic [32:0]         div_rem   [DIV_N+1];
  logic [33:0]         div_den   [DIV_N+1];
  logic [OUT_BITS:0]   div_low   [DIV_N+1];
  logic [OUT_BITS:0]   div_quo   [DIV_N+1];
  logic                div_last  [DIV_N+1];

  // output register
  logic                out_valid_r;
  logic [OUT_BITS-1:0] out_y_r;
  logic [OUT_BITS-1:0] out_y_nxt;
  logic                out_last_r;

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // ---- entry: sign and magnitude ----
  assign neg = in_chan.x_value[XW-1];
  always_comb begin
    entry_nxt.last = in_chan.last_in;
    entry_nxt.neg  = neg;
    entry_nxt.mag  = neg ? (XW'(0) - in_chan.x_value) : in_chan.x_value;
    entry_nxt.one  = 1'b1;
    entry_nxt.acc  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_valid[0] <= 1'b0;
    end else if (en) begin
      exp_valid[0] <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      exp_data[0] <= entry_nxt;
    end
  end

  // ---- exponent chain, low magnitude bit first ----
  for (genvar b = 0; b < XW; b++) begin : g_exp
    sge_exp_stage #(
      .BIT_POS (b)
    ) u_exp (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (exp_valid[b]),
      .in_data     (exp_data[b]),
      .out_valid_r (exp_valid[b+1]),
      .out_data_r  (exp_data[b+1])
    );
  end

  // ---- dividend: (num << OUT_BITS) + den/2 ----
  assign e_full   = exp_data[XW].one ? 33'h1_0000_0000 : {1'b0, exp_data[XW].acc};
  assign den_nxt  = 34'h1_0000_0000 + {1'b0, e_full};
  assign num      = exp_data[XW].neg ? e_full : 33'h1_0000_0000;
  assign dividend = (NW'(num) << OUT_BITS) + NW'(den_nxt[33:1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_valid[0] <= 1'b0;
    end else if (en) begin
      div_valid[0] <= exp_valid[XW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_rem[0]  <= dividend[NW-1:OUT_BITS+1];
      div_den[0]  <= den_nxt;
      div_low[0]  <= dividend[OUT_BITS:0];
      div_quo[0]  <= '0;
      div_last[0] <= exp_data[XW].last;
    end
  end

  // ---- divider chain, one quotient bit per stage ----
  for (genvar s = 0; s < DIV_N; s++) begin : g_div
    sge_div_stage #(
      .OUT_BITS (OUT_BITS)
    ) u_div (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (div_valid[s]),
      .in_rem      (div_rem[s]),
      .in_den      (div_den[s]),
      .in_low      (div_low[s]),
      .in_quo      (div_quo[s]),
      .in_last     (div_last[s]),
      .out_valid_r (div_valid[s+1]),
      .out_rem_r   (div_rem[s+1]),
      .out_den_r   (div_den[s+1]),
      .out_low_r   (div_low[s+1]),
      .out_quo_r   (div_quo[s+1]),
      .out_last_r  (div_last[s+1])
    );
  end

  // ---- saturate and hold for the receiver ----
  assign out_y_nxt = div_quo[DIV_N][OUT_BITS] ? '1 : div_quo[DIV_N][OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_y_r    <= out_y_nxt;
      out_last_r <= div_last[DIV_N];
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.y_value  = out_y_r;
  assign out_chan.last_out = out_last_r;

  // ---- checks ----
  // the exponential leaves 1.0 exactly when the magnitude is zero
  a_exp_one_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
    exp_valid[XW] |-> ((exp_data[XW].mag == '0) == exp_data[XW].one))
    else $error("exponent chain: one flag disagrees with magnitude");

  // the divider ends with a proper remainder and all dividend bits consumed
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid[DIV_N] |-> ({1'b0, div_rem[DIV_N]} < div_den[DIV_N]) &&
                         (div_low[DIV_N] == '0))
    else $error("divider: remainder not below divisor");

  // a held result is not replaced by the stage behind it
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_y_r) &&
                                       $stable(div_valid[DIV_N]))
    else $error("output register: held result changed");

endmodule

>>> rtl/core/sge_exp_stage.sv
// ----------------------------------------------------------------------------
// sge_exp_stage: one step of the table-based exponential
// Multiplies the accumulator by exp(-2^j) when magnitude bit BIT_POS is set.
// ----------------------------------------------------------------------------
module sge_exp_stage #(
  parameter int BIT_POS = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  sge_pkg::exp_data_t in_data,
  output logic               out_valid_r,
  output sge_pkg::exp_data_t out_data_r
);

  localparam int IDX = BIT_POS + sge_pkg::ROM_LOW_EXP - sge_pkg::IN_FRAC_BITS;
  localparam bit ACTIVE = (IDX >= 0);
  localparam logic [sge_pkg::EXP_W-1:0] FACTOR = sge_pkg::exp_factor(IDX);

  logic [2*sge_pkg::EXP_W-1:0] prod;
  logic [2*sge_pkg::EXP_W-1:0] prod_rnd;
  sge_pkg::exp_data_t          out_data_nxt;

  assign prod     = in_data.acc * FACTOR;
  assign prod_rnd = prod + (64'd1 << (sge_pkg::EXP_W - 1));

  always_comb begin
    out_data_nxt = in_data;
    if (ACTIVE && in_data.mag[BIT_POS]) begin
      out_data_nxt.one = 1'b0;
      // 1.0 times the factor is the factor itself
      if (in_data.one) begin
        out_data_nxt.acc = FACTOR;
      end else begin
        out_data_nxt.acc = prod_rnd[2*sge_pkg::EXP_W-1:sge_pkg::EXP_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> rtl/core/sge_div_stage.sv
// ----------------------------------------------------------------------------
// sge_div_stage: one quotient bit of the restoring divider
// Shifts in the next dividend bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module sge_div_stage #(
  parameter int OUT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [32:0]         in_rem,
  input  logic [33:0]         in_den,
  input  logic [OUT_BITS:0]   in_low,
  input  logic [OUT_BITS:0]   in_quo,
  input  logic                in_last,
  output logic                out_valid_r,
  output logic [32:0]         out_rem_r,
  output logic [33:0]         out_den_r,
  output logic [OUT_BITS:0]   out_low_r,
  output logic [OUT_BITS:0]   out_quo_r,
  output logic                out_last_r
);

  logic [33:0]       trial;
  logic [33:0]       diff;
  logic              fits;
  logic [32:0]       out_rem_nxt;
  logic [OUT_BITS:0] out_low_nxt;
  logic [OUT_BITS:0] out_quo_nxt;

  assign trial       = {in_rem, in_low[OUT_BITS]};
  assign diff        = trial - in_den;
  assign fits        = (trial >= in_den);
  // remainder stays below the divisor, which is at most 2^33
  assign out_rem_nxt = fits ? diff[32:0] : trial[32:0];
  assign out_low_nxt = {in_low[OUT_BITS-1:0], 1'b0};
  assign out_quo_nxt = {in_quo[OUT_BITS-1:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem_r  <= out_rem_nxt;
      out_den_r  <= in_den;
      out_low_r  <= out_low_nxt;
      out_quo_r  <= out_quo_nxt;
      out_last_r <= in_last;
    end
  end

endmodule
